>>> sv/ihr_pkg.sv
// Shared types and constants of the intensity histogram block.
package ihr_pkg;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SCALE_8  = 2'd0,
      SCALE_12 = 2'd1,
      SCALE_16 = 2'd2
   } scale_type;

   localparam logic [1:0] FMT_BYTE  = 2'd0;
   localparam logic [1:0] FMT_ALPHA = 2'd1;

   localparam logic [1:0] REG_BUCKET_COUNT  = 2'd0;
   localparam logic [1:0] REG_SOURCE_FORMAT = 2'd1;
   localparam logic [1:0] REG_TWELVE_BIT    = 2'd2;

   localparam int NB_BITS      = 9;
   localparam int VALUE_BITS   = 16;
   localparam int PRODUCT_BITS = 25;
   localparam int QUOT_BITS    = 13;
   localparam int RECIP_BITS   = 19;
   localparam int RECIP_SHIFT  = 26;

   localparam logic [RECIP_BITS-1:0] RECIP_8  = 19'd263172;
   localparam logic [RECIP_BITS-1:0] RECIP_12 = 19'd16388;
   localparam logic [RECIP_BITS-1:0] RECIP_16 = 19'd1024;

   localparam logic [4:0] SHIFT_8  = 5'd8;
   localparam logic [4:0] SHIFT_12 = 5'd12;
   localparam logic [4:0] SHIFT_16 = 5'd16;

   typedef struct packed {
      logic [NB_BITS-1:0] bucket_count;
      logic [1:0]         source_format;
      logic               twelve_bit_stored;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic scale;
      logic divide;
      logic correct;
      logic update;
      logic load_read;
      logic sweep;
      logic publish;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   dropped;
      logic   index_ok;
      logic   sweep_last;
      logic   out_free;
   } status_type;

   typedef enum logic [10:0] {
      ST_INIT    = 11'b000_0000_0001,
      ST_IDLE    = 11'b000_0000_0010,
      ST_SCALE   = 11'b000_0000_0100,
      ST_DIVIDE  = 11'b000_0000_1000,
      ST_CORRECT = 11'b000_0001_0000,
      ST_FETCH   = 11'b000_0010_0000,
      ST_UPDATE  = 11'b000_0100_0000,
      ST_LOOKUP  = 11'b000_1000_0000,
      ST_READ    = 11'b001_0000_0000,
      ST_CLEAR   = 11'b010_0000_0000,
      ST_DONE    = 11'b100_0000_0000
   } state_type;

endpackage

>>> sv/intensity_histogram_with_range_unit.sv
// Top level of the intensity histogram with peak count and range of hit buckets.
//
// Items arrive on the req_ stream: tuser carries the operation (add sample, read
// bucket, clear, or no operation) and tdata the sample word and bucket index.
// Every item answers with exactly one item on the rsp_ stream, which carries the
// bucket count, the largest count, the hit range and, in tuser, the dropped flag.
// The block works on one item at a time, set by the read-modify-write of the
// count memory behind the bucket mapping steps (multiply, reciprocal
// multiply, correction). An add item skips the count update when the sample is
// dropped, a read item skips the memory read when the index is beyond the
// bucket count, and a clear item sweeps the count memory one entry per cycle.
// The result is in the output register by the time the next item can be
// taken. After reset the block sweeps every entry of the count memory with
// req_tready low, while configuration writes are taken throughout. When the
// receiver stalls, the held result stays in the output register; the next
// item is still accepted and worked on, and waits for the register to free.
// The csr_ port is an APB-style port with registers bucket_count at 0x0,
// source_format at 0x4 and twelve_bit_stored at 0x8; pready is always high.
module intensity_histogram_with_range_unit import ihr_pkg::*; #(
   parameter int MAX_BUCKETS = 256,
   parameter int COUNT_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sample [31:0], bucket_index [39:32]
   input  logic [39:0] req_tdata,
   // op [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // count [31:0], max_count [63:32], range_low [72:64], range_high [81:73], zero [87:82]
   output logic [87:0] rsp_tdata,
   // dropped [0]
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;
   logic       csr_write;
   logic [31:0]        rsp_count;
   logic [31:0]        rsp_max_count;
   logic [NB_BITS-1:0] rsp_range_low;
   logic [NB_BITS-1:0] rsp_range_high;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bucket_count      <= NB_BITS'(256);
         cfg_ff.source_format     <= FMT_BYTE;
         cfg_ff.twelve_bit_stored <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_BUCKET_COUNT:  cfg_ff.bucket_count      <= csr_pwdata[NB_BITS-1:0];
            REG_SOURCE_FORMAT: cfg_ff.source_format     <= csr_pwdata[1:0];
            REG_TWELVE_BIT:    cfg_ff.twelve_bit_stored <= csr_pwdata[0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_BUCKET_COUNT:  csr_prdata = 32'(cfg_ff.bucket_count);
         REG_SOURCE_FORMAT: csr_prdata = 32'(cfg_ff.source_format);
         REG_TWELVE_BIT:    csr_prdata = 32'(cfg_ff.twelve_bit_stored);
         default:           csr_prdata = '0;
      endcase
   end

   ihr_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status(status),
      .cmd(cmd)
   );

   ihr_datapath #(
      .MAX_BUCKETS(MAX_BUCKETS),
      .COUNT_BITS(COUNT_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .req_op(req_tuser),
      .req_sample(req_tdata[31:0]),
      .req_bucket_index(req_tdata[39:32]),
      .cmd(cmd),
      .status(status),
      .rsp_tready(rsp_tready),
      .rsp_valid(rsp_tvalid),
      .rsp_count(rsp_count),
      .rsp_max_count(rsp_max_count),
      .rsp_range_low(rsp_range_low),
      .rsp_range_high(rsp_range_high),
      .rsp_dropped(rsp_tuser)
   );

   assign rsp_tdata = {6'd0, rsp_range_high, rsp_range_low, rsp_max_count, rsp_count};

endmodule

>>> sv/ihr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ihr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/ihr_ctrl.sv
// Controller state machine that sequences each histogram item.
module ihr_ctrl import ihr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               unique case (status.op)
                  OP_ADD:   state_in = ST_SCALE;
                  OP_READ:  state_in = ST_LOOKUP;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_NOP:   state_in = ST_DONE;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
            state_in   = ST_CORRECT;
         end
         ST_CORRECT: begin
            cmd.correct = 1'b1;
            state_in    = ST_FETCH;
         end
         ST_FETCH: begin
            if (status.dropped) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DONE;
         end
         ST_LOOKUP: begin
            if (status.index_ok) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.load_read = 1'b1;
            state_in      = ST_DONE;
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/ihr_datapath.sv
// Datapath: bucket mapping, count store, statistics and result register.
module ihr_datapath import ihr_pkg::*; #(
   parameter int MAX_BUCKETS = 256,
   parameter int COUNT_BITS  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic [1:0]          req_op,
   input  logic [31:0]         req_sample,
   input  logic [7:0]          req_bucket_index,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                rsp_tready,
   output logic                rsp_valid,
   output logic [31:0]         rsp_count,
   output logic [31:0]         rsp_max_count,
   output logic [NB_BITS-1:0]  rsp_range_low,
   output logic [NB_BITS-1:0]  rsp_range_high,
   output logic                rsp_dropped
);

   localparam int AW       = $clog2(MAX_BUCKETS);
   localparam int CAP      = (MAX_BUCKETS < 511) ? MAX_BUCKETS : 511;
   localparam int MULW     = PRODUCT_BITS + RECIP_BITS;
   localparam logic [NB_BITS-1:0]    NB_CAP    = NB_BITS'(CAP);
   localparam logic [AW-1:0]         SWEEP_END = AW'(MAX_BUCKETS - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [31:0]             sample_ff;
   logic [7:0]              index_ff;
   logic [PRODUCT_BITS-1:0] prod_ff;
   scale_type               scale_ff;
   logic [QUOT_BITS-1:0]    quot_ff;
   logic [NB_BITS-1:0]      bucket_ff;
   logic [AW-1:0]           addr_ff;
   logic                    drop_ff;
   logic [COUNT_BITS-1:0]   res_count_ff;
   logic [COUNT_BITS-1:0]   largest_ff;
   logic                    any_hit_ff;
   logic [NB_BITS-1:0]      lowest_ff;
   logic [NB_BITS-1:0]      highest_ff;
   logic [AW-1:0]           sweep_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [31:0]             rsp_count_ff;
   logic [31:0]             rsp_max_ff;
   logic [NB_BITS-1:0]      rsp_low_ff;
   logic [NB_BITS-1:0]      rsp_high_ff;
   logic                    rsp_drop_ff;

   logic [NB_BITS-1:0]      nb;
   logic [VALUE_BITS-1:0]   value;
   scale_type               scale_sel;
   logic [RECIP_BITS-1:0]   recip;
   logic [MULW-1:0]         recip_prod;
   logic [4:0]              shift;
   logic [31:0]             qd;
   logic [31:0]             divisor;
   logic [31:0]             remainder;
   logic [QUOT_BITS-1:0]    quot_fix;
   logic [QUOT_BITS-1:0]    index_wide;
   logic [COUNT_BITS-1:0]   rd_count;
   logic [COUNT_BITS-1:0]   new_count;
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [COUNT_BITS-1:0]   ram_wdata;

   always_comb begin
      priority if (cfg.bucket_count == '0) begin
         nb = NB_BITS'(1);
      end else if (cfg.bucket_count > NB_CAP) begin
         nb = NB_CAP;
      end else begin
         nb = cfg.bucket_count;
      end
   end

   always_comb begin
      unique case (cfg.source_format)
         FMT_BYTE: begin
            value     = {8'd0, sample_ff[7:0]};
            scale_sel = SCALE_8;
         end
         FMT_ALPHA: begin
            value     = {8'd0, sample_ff[31:24]};
            scale_sel = SCALE_8;
         end
         default: begin
            value     = sample_ff[15:0];
            scale_sel = cfg.twelve_bit_stored ? SCALE_12 : SCALE_16;
         end
      endcase
   end

   always_comb begin
      unique case (scale_ff)
         SCALE_8: begin
            recip = RECIP_8;
            shift = SHIFT_8;
         end
         SCALE_12: begin
            recip = RECIP_12;
            shift = SHIFT_12;
         end
         default: begin
            recip = RECIP_16;
            shift = SHIFT_16;
         end
      endcase
   end

   assign recip_prod = MULW'(prod_ff) * MULW'(recip);
   assign qd         = (32'(quot_ff) << shift) - 32'(quot_ff);
   assign divisor    = (32'd1 << shift) - 32'd1;
   assign remainder  = 32'(prod_ff) - qd;
   assign quot_fix   = (remainder >= divisor) ? quot_ff + QUOT_BITS'(1) : quot_ff;
   assign index_wide = QUOT_BITS'(req_bucket_index);
   assign new_count  = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_BITS'(1);

   assign ram_we    = cmd.update | cmd.sweep;
   assign ram_waddr = cmd.sweep ? sweep_ff : addr_ff;
   assign ram_wdata = cmd.sweep ? '0 : new_count;

   ihr_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(MAX_BUCKETS)
   ) u_counts (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(addr_ff),
      .rdata(rd_count)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff    <= req_sample;
         index_ff     <= req_bucket_index;
         addr_ff      <= index_wide[AW-1:0];
         drop_ff      <= 1'b0;
         res_count_ff <= '0;
      end
      if (cmd.scale) begin
         prod_ff  <= PRODUCT_BITS'(value) * PRODUCT_BITS'(nb - NB_BITS'(1));
         scale_ff <= scale_sel;
      end
      if (cmd.divide) begin
         quot_ff <= recip_prod[RECIP_SHIFT +: QUOT_BITS];
      end
      if (cmd.correct) begin
         bucket_ff <= quot_fix[NB_BITS-1:0];
         addr_ff   <= quot_fix[AW-1:0];
         drop_ff   <= quot_fix >= QUOT_BITS'(nb);
      end
      if (cmd.load_read) begin
         res_count_ff <= rd_count;
      end
      if (cmd.update) begin
         res_count_ff <= new_count;
         if (new_count > largest_ff) begin
            largest_ff <= new_count;
         end
         if (!any_hit_ff || bucket_ff < lowest_ff) begin
            lowest_ff <= bucket_ff;
         end
         if (!any_hit_ff || bucket_ff > highest_ff) begin
            highest_ff <= bucket_ff;
         end
      end
      if (cmd.sweep) begin
         largest_ff <= '0;
         lowest_ff  <= '0;
         highest_ff <= '0;
      end
      if (cmd.publish) begin
         rsp_count_ff <= 32'(res_count_ff);
         rsp_max_ff   <= 32'(largest_ff);
         rsp_low_ff   <= any_hit_ff ? lowest_ff : nb;
         rsp_high_ff  <= any_hit_ff ? highest_ff : '1;
         rsp_drop_ff  <= drop_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_hit_ff   <= 1'b0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.update) begin
            any_hit_ff <= 1'b1;
         end
         if (cmd.sweep) begin
            any_hit_ff <= 1'b0;
            sweep_ff   <= (sweep_ff == SWEEP_END) ? '0 : sweep_ff + AW'(1);
         end
      end
   end

   assign status.op         = op_type'(req_op);
   assign status.dropped    = drop_ff;
   assign status.index_ok   = NB_BITS'(index_ff) < nb;
   assign status.sweep_last = sweep_ff == SWEEP_END;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_max_count  = rsp_max_ff;
   assign rsp_range_low  = rsp_low_ff;
   assign rsp_range_high = rsp_high_ff;
   assign rsp_dropped    = rsp_drop_ff;

endmodule
